FILE: rtl/dpgd_pkg.sv
`default_nettype none
package dpgd_pkg;

    localparam int MAX_SPEAKERS = 16;
    localparam int RESULT_CAP   = 16;
    localparam int EFF_MAX      = (MAX_SPEAKERS < RESULT_CAP) ? MAX_SPEAKERS : RESULT_CAP;
    localparam int EXP_STEPS    = 16;

    localparam logic [15:0] LOG2_BASE_RST = 16'd1872;
    localparam logic [15:0] SPM_RST       = 16'd35824;
    localparam logic [4:0]  ACTIVE_RST    = 5'd1;

    // configuration register indexes
    localparam logic [1:0] REG_LOG2_BASE = 2'd0;
    localparam logic [1:0] REG_SPM       = 2'd1;
    localparam logic [1:0] REG_ACTIVE    = 2'd2;

    typedef enum logic [4:0] {
        ST_INIT_RT,
        ST_INIT_WAIT,
        ST_IDLE,
        ST_MIN_SQ,
        ST_MIN_RT,
        ST_MIN_WAIT,
        ST_D_SQ,
        ST_D_RT,
        ST_D_WAIT,
        ST_R_SQ,
        ST_R_RT,
        ST_R_WAIT,
        ST_EXP,
        ST_GA,
        ST_GB,
        ST_GFIN,
        ST_PATH,
        ST_DLY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic       accept;
        logic       sq_en;
        logic       sq_first;
        logic       sq_origin;
        logic [1:0] axis;
        logic [3:0] idx;
        logic [3:0] k;
        logic       rt_start;
        logic       rt_sel_t;
        logic       cap_t;
        logic       cap_d2;
        logic       cap_d;
        logic       cap_r;
        logic       min_upd;
        logic       min_first;
        logic       exp_en;
        logic       ga_en;
        logic       gb_en;
        logic       gfin_en;
        logic       path_en;
        logic       dly_en;
        logic       emit_en;
        logic       emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] in_idx;
        logic       idx_ok;
        logic [3:0] last_idx;
        logic       out_free;
        logic       rt_done;
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/dpgd_sqrt.sv
`default_nettype none
// Digit-by-digit square root, one result bit a cycle, rounded to nearest.
module dpgd_sqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] x,
    output logic             done,
    output logic [32:0]      root
);
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] x_reg, x_next;
    logic [33:0] rem_reg, rem_next;
    logic [32:0] root_reg, root_next;
    logic [35:0] cat;
    logic [35:0] trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cat       = {rem_reg, x_reg[63:62]};
        trial     = {2'b00, root_reg[31:0], 2'b01};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd32;
            x_next    = x;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg && cnt_reg != 6'd0)
        begin
            x_next   = {x_reg[61:0], 2'b00};
            cnt_next = cnt_reg - 6'd1;
            if (cat >= trial)
            begin
                rem_next  = 34'(cat - trial);
                root_next = {root_reg[31:0], 1'b1};
            end
            else
            begin
                rem_next  = cat[33:0];
                root_next = {root_reg[31:0], 1'b0};
            end
        end
        else if (busy_reg)
        begin
            // round to nearest: up when x - r^2 > r
            if (rem_reg > {1'b0, root_reg})
                root_next = root_reg + 33'd1;
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule
`default_nettype wire

FILE: rtl/dpgd_datapath.sv
`default_nettype none
module dpgd_datapath (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dpgd_pkg::dp_cmd_t  cmd,
    output dpgd_pkg::dp_stat_t      stat,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    input  wire logic               kind,
    input  wire logic [3:0]         speaker_index,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [15:0] pos_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [3:0]              out_speaker,
    output logic [15:0]             gain,
    output logic [23:0]             delay_samples,
    output logic                    last
);
    import dpgd_pkg::*;

    logic [15:0] log2_base_reg;
    logic [15:0] spm_reg;
    logic [4:0]  active_reg;
    logic signed [15:0] src_reg [3];
    logic signed [15:0] spk_reg [MAX_SPEAKERS][3];
    logic [16:0] min_reg;
    logic [31:0] t_reg;
    logic [31:0] tk_reg [EXP_STEPS];
    logic        out_valid_reg;

    logic [33:0] acc_reg;
    logic [33:0] d2_reg;
    logic [16:0] d_reg;
    logic [16:0] r_reg;
    logic        big_reg;
    logic [4:0]  n_reg;
    logic [15:0] f_reg;
    logic [32:0] m_reg;
    logic [48:0] pp_reg;
    logic [15:0] gain_reg;
    logic [17:0] p_reg;
    logic [23:0] delay_reg;
    logic [3:0]  out_spk_reg;
    logic [15:0] out_gain_reg;
    logic [23:0] out_delay_reg;
    logic        out_last_reg;

    logic [4:0]  eff_n;
    logic signed [15:0] sq_a, sq_b;
    logic signed [16:0] diff;
    logic [15:0] mag;
    logic [31:0] sq;
    logic [63:0] rt_x;
    logic        rt_done;
    logic [32:0] rt_root;
    logic [49:0] e_full;
    logic [48:0] prodh;
    logic [64:0] full;
    logic [47:0] gsum, gshift;
    logic [5:0]  nsh;
    logic signed [18:0] path;
    logic [33:0] dprod;
    logic [34:0] dround;
    logic [16:0] rt_res;

    // effective speaker count, 1..EFF_MAX
    always_comb
    begin
        if (active_reg == 5'd0)
            eff_n = 5'd1;
        else if (active_reg > 5'(EFF_MAX))
            eff_n = 5'(EFF_MAX);
        else
            eff_n = active_reg;
    end

    always_comb
    begin
        stat.kind     = kind;
        stat.in_idx   = speaker_index;
        stat.idx_ok   = ({1'b0, speaker_index} < eff_n);
        stat.last_idx = 4'(eff_n - 5'd1);
        stat.out_free = !out_valid_reg || !out_stall;
        stat.rt_done  = rt_done;
    end

    // one squared axis difference per cycle
    always_comb
    begin
        sq_a = cmd.sq_origin ? 16'sd0 : src_reg[cmd.axis];
        sq_b = spk_reg[cmd.idx][cmd.axis];
        diff = 17'(sq_a) - 17'(sq_b);
        mag  = diff[16] ? 16'(-diff) : diff[15:0];
        sq   = mag * mag;
    end

    assign rt_x   = cmd.rt_sel_t ? {t_reg, 32'd0} : {30'd0, acc_reg};
    assign rt_res = rt_root[16:0];

    dpgd_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.rt_start),
        .x     (rt_x),
        .done  (rt_done),
        .root  (rt_root)
    );

    always_comb
    begin
        e_full = d2_reg * log2_base_reg;
        prodh  = m_reg * tk_reg[cmd.k][31:16];
        full   = {prodh, 16'd0} + {16'd0, pp_reg} + 65'h0_8000_0000;
        nsh    = {1'b0, n_reg};
        gsum   = {15'd0, m_reg} + (48'd1 << (6'd15 + nsh));
        gshift = gsum >> (6'd16 + nsh);
        path   = 19'({2'b00, d_reg}) + 19'({2'b00, r_reg}) - 19'({2'b00, min_reg});
        dprod  = p_reg * spm_reg;
        dround = {1'b0, dprod} + 35'd128;
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log2_base_reg <= LOG2_BASE_RST;
            spm_reg       <= SPM_RST;
            active_reg    <= ACTIVE_RST;
            min_reg       <= '0;
            t_reg         <= 32'h8000_0000;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 3; a++)
                src_reg[a] <= '0;
            for (int s = 0; s < MAX_SPEAKERS; s++)
                for (int a = 0; a < 3; a++)
                    spk_reg[s][a] <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOG2_BASE: log2_base_reg <= cfg_data;
                    REG_SPM:       spm_reg       <= cfg_data;
                    REG_ACTIVE:    active_reg    <= cfg_data[4:0];
                    default:       ;
                endcase
            end
            if (cmd.accept)
            begin
                if (!kind)
                begin
                    src_reg[0] <= pos_x;
                    src_reg[1] <= pos_y;
                    src_reg[2] <= pos_z;
                end
                else if (stat.idx_ok)
                begin
                    spk_reg[speaker_index][0] <= pos_x;
                    spk_reg[speaker_index][1] <= pos_y;
                    spk_reg[speaker_index][2] <= pos_z;
                end
            end
            if (cmd.cap_t)
                t_reg <= rt_root[31:0];
            if (cmd.min_upd && (cmd.min_first || rt_res < min_reg))
                min_reg <= rt_res;
            if (cmd.emit_en)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.cap_t)
            tk_reg[cmd.k] <= rt_root[31:0];
        if (cmd.sq_en)
            acc_reg <= cmd.sq_first ? {2'b00, sq} : acc_reg + {2'b00, sq};
        if (cmd.cap_d2)
            d2_reg <= acc_reg;
        if (cmd.cap_d)
            d_reg <= rt_res;
        if (cmd.cap_r)
            r_reg <= rt_res;
        if (cmd.exp_en)
        begin
            big_reg <= |e_full[49:37];
            n_reg   <= e_full[36:32];
            f_reg   <= e_full[31:16];
            m_reg   <= 33'h1_0000_0000;
        end
        if (cmd.ga_en)
            pp_reg <= m_reg * tk_reg[cmd.k][15:0];
        if (cmd.gb_en && f_reg[4'd15 - cmd.k])
            m_reg <= full[64:32];
        if (cmd.gfin_en)
        begin
            if (big_reg)
                gain_reg <= '0;
            else if (gshift > 48'd65535)
                gain_reg <= 16'hFFFF;
            else
                gain_reg <= gshift[15:0];
        end
        if (cmd.path_en)
            p_reg <= path[18] ? 18'd0 : path[17:0];
        if (cmd.dly_en)
            delay_reg <= (|dround[34:32]) ? 24'hFF_FFFF : dround[31:8];
        if (cmd.emit_en)
        begin
            out_spk_reg   <= cmd.idx;
            out_gain_reg  <= gain_reg;
            out_delay_reg <= delay_reg;
            out_last_reg  <= cmd.emit_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_speaker   = out_spk_reg;
    assign gain          = out_gain_reg;
    assign delay_samples = out_delay_reg;
    assign last          = out_last_reg;
endmodule
`default_nettype wire

FILE: rtl/dpgd_ctrl.sv
`default_nettype none
module dpgd_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire dpgd_pkg::dp_stat_t stat,
    output dpgd_pkg::dp_cmd_t       cmd
);
    import dpgd_pkg::*;

    state_t     state_reg, state_next;
    logic [3:0] idx_reg, idx_next;
    logic [3:0] sp_reg, sp_next;
    logic [3:0] k_reg, k_next;
    logic [1:0] axis_reg, axis_next;
    logic       single_reg, single_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT_RT;
            idx_reg    <= '0;
            sp_reg     <= '0;
            k_reg      <= '0;
            axis_reg   <= '0;
            single_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            sp_reg     <= sp_next;
            k_reg      <= k_next;
            axis_reg   <= axis_next;
            single_reg <= single_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        sp_next       = sp_reg;
        k_next        = k_reg;
        axis_next     = axis_reg;
        single_next   = single_reg;
        cmd           = '0;
        cmd.idx       = idx_reg;
        cmd.k         = k_reg;
        cmd.axis      = axis_reg;
        cmd.sq_first  = (axis_reg == 2'd0);
        in_stall      = (state_reg != ST_IDLE);
        case (state_reg)
            ST_INIT_RT:
            begin
                cmd.rt_start = 1'b1;
                cmd.rt_sel_t = 1'b1;
                state_next   = ST_INIT_WAIT;
            end
            ST_INIT_WAIT:
            begin
                if (stat.rt_done)
                begin
                    cmd.cap_t = 1'b1;
                    if (k_reg == 4'(EXP_STEPS - 1))
                    begin
                        k_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + 4'd1;
                        state_next = ST_INIT_RT;
                    end
                end
            end
            ST_IDLE:
            begin
                axis_next = '0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    idx_next   = '0;
                    if (!stat.kind)
                    begin
                        single_next = 1'b0;
                        state_next  = ST_D_SQ;
                    end
                    else if (stat.idx_ok)
                    begin
                        single_next = 1'b1;
                        sp_next     = stat.in_idx;
                        state_next  = ST_MIN_SQ;
                    end
                end
            end
            ST_MIN_SQ, ST_D_SQ, ST_R_SQ:
            begin
                cmd.sq_en     = 1'b1;
                cmd.sq_origin = (state_reg != ST_D_SQ);
                if (axis_reg == 2'd2)
                begin
                    axis_next = '0;
                    case (state_reg)
                        ST_MIN_SQ: state_next = ST_MIN_RT;
                        ST_D_SQ:   state_next = ST_D_RT;
                        default:   state_next = ST_R_RT;
                    endcase
                end
                else
                    axis_next = axis_reg + 2'd1;
            end
            ST_MIN_RT:
            begin
                cmd.rt_start = 1'b1;
                state_next   = ST_MIN_WAIT;
            end
            ST_MIN_WAIT:
            begin
                if (stat.rt_done)
                begin
                    cmd.min_upd   = 1'b1;
                    cmd.min_first = (idx_reg == 4'd0);
                    if (idx_reg == stat.last_idx)
                    begin
                        idx_next   = sp_reg;
                        state_next = ST_D_SQ;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 4'd1;
                        state_next = ST_MIN_SQ;
                    end
                end
            end
            ST_D_RT:
            begin
                cmd.rt_start = 1'b1;
                cmd.cap_d2   = 1'b1;
                state_next   = ST_D_WAIT;
            end
            ST_D_WAIT:
            begin
                if (stat.rt_done)
                begin
                    cmd.cap_d  = 1'b1;
                    state_next = ST_R_SQ;
                end
            end
            ST_R_RT:
            begin
                cmd.rt_start = 1'b1;
                state_next   = ST_R_WAIT;
            end
            ST_R_WAIT:
            begin
                if (stat.rt_done)
                begin
                    cmd.cap_r  = 1'b1;
                    state_next = ST_EXP;
                end
            end
            ST_EXP:
            begin
                cmd.exp_en = 1'b1;
                k_next     = '0;
                state_next = ST_GA;
            end
            ST_GA:
            begin
                cmd.ga_en  = 1'b1;
                state_next = ST_GB;
            end
            ST_GB:
            begin
                cmd.gb_en = 1'b1;
                if (k_reg == 4'(EXP_STEPS - 1))
                begin
                    k_next     = '0;
                    state_next = ST_GFIN;
                end
                else
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = ST_GA;
                end
            end
            ST_GFIN:
            begin
                cmd.gfin_en = 1'b1;
                state_next  = ST_PATH;
            end
            ST_PATH:
            begin
                cmd.path_en = 1'b1;
                state_next  = ST_DLY;
            end
            ST_DLY:
            begin
                cmd.dly_en = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit_en   = 1'b1;
                    cmd.emit_last = single_reg || (idx_reg == stat.last_idx);
                    if (cmd.emit_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + 4'd1;
                        state_next = ST_D_SQ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/distance_panning_gain_delay.sv
`default_nettype none
// Each speaker result takes two square-root passes and 16 exp2 steps.
// A source update yields one result per active speaker; a speaker update first runs the
// minimum-distance sweep over the active speakers, then yields the one result.
// One item at a time; the shared square-root unit sets the pace.
// Reset is asynchronous, active low; afterwards a sweep builds the exp2 root
// table, during which in_stall stays high (config writes still taken).
module distance_panning_gain_delay (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration write port
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_data,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic [3:0]         speaker_index,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [15:0] pos_z,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [3:0]              out_speaker,
    output logic [15:0]             gain,
    output logic [23:0]             delay_samples,
    output logic                    last
);
    import dpgd_pkg::*;

    // command and status between sequencer and datapath
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: table init, min sweep, per-speaker evaluation, result beats
    dpgd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // positions, config, root unit, exp2 and delay arithmetic, output register
    dpgd_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .kind          (kind),
        .speaker_index (speaker_index),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_speaker   (out_speaker),
        .gain          (gain),
        .delay_samples (delay_samples),
        .last          (last)
    );
endmodule
`default_nettype wire
